>>> rtl/round_robin_sleep_scheduler_macros.svh
// Assertion macros shared by the scheduler checker.
`ifndef ROUND_ROBIN_SLEEP_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_SLEEP_SCHEDULER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define RRSS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define RRSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rrss_pkg.sv
// Shared types and codes of the round-robin sleep scheduler.
package rrss_pkg;

  localparam int SLOT_W = 3;
  localparam int MS_W   = 32;
  localparam int DUR_W  = 31;
  localparam int CMD_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SLEEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd3;

  // Slot status codes; code 3 behaves like idle
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACTIVE = 2'd1;
  localparam logic [1:0] ST_SLEEP  = 2'd2;

  // One thread slot as it travels around the ring
  typedef struct packed {
    logic            used;
    logic [1:0]      status;
    logic [MS_W-1:0] sbegin;
    logic [MS_W-1:0] slen;
  } slot_t;

  localparam slot_t SLOT_RST_HEAD = '{used: 1'b1, status: ST_ACTIVE, sbegin: '0, slen: '0};
  localparam slot_t SLOT_RST_FREE = '{used: 1'b0, status: ST_IDLE, sbegin: '0, slen: '0};

endpackage

>>> rtl/rrss_cell.sv
// One ring cell: holds a thread slot, wakes it on tick, hands it to its neighbor.
module rrss_cell
  import rrss_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  slot_t           rst_val,
  input  logic            shift,
  input  logic            wake_en,
  input  logic [MS_W-1:0] ms,
  input  slot_t           from_next,
  output slot_t           to_prev
);

  slot_t           slot_r;
  logic [MS_W-1:0] elapsed;
  logic            wake;

  // Elapsed time wraps modulo 2^32
  assign elapsed = ms - slot_r.sbegin;
  assign wake    = wake_en && slot_r.used && (slot_r.status == ST_SLEEP)
                   && (elapsed > slot_r.slen);

  // Word handed on, with the sleeper woken when its time is up
  always_comb begin
    to_prev = slot_r;
    if (wake) begin
      to_prev.status = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= rst_val;
    end else if (shift) begin
      slot_r <= from_next;
    end
  end

endmodule

>>> rtl/round_robin_sleep_scheduler.sv
// Top level: round-robin thread scheduler with sleep timers over a ring of slot cells.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | command, duration
//   out_    | output    | out_valid / out_ready| switched .. tick_count
//
// The slot table is a ring of NUM_SLOTS cells that rotates by one slot per cycle past
// the head during a pass, where the controller reads and edits it. Sleep, start and
// end take one full rotation, a tick takes two (wake and scan, then update); the result
// is then loaded in the done state and the block returns to idle, so it takes no new
// word before the last one is through.
// Reset (synchronous, rst_n low) restores slot 0 as the running thread at once.
// A result waiting on out_ready holds only the final load step of the next item.
module round_robin_sleep_scheduler
  import rrss_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [DUR_W-1:0]  in_duration,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_switched,
  output logic              out_old_valid,
  output logic [SLOT_W-1:0] out_old_slot,
  output logic [SLOT_W-1:0] out_new_slot,
  output logic [SLOT_W-1:0] out_started_slot,
  output logic              out_table_full,
  output logic              out_none_runnable,
  output logic [MS_W-1:0]   out_tick_count
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_PASS1, S_PASS2, S_DONE} state_t;

  state_t            state_r;
  logic [IW-1:0]     idx_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [DUR_W-1:0]  dur_r;
  logic [MS_W-1:0]   ms_r;
  logic [IW-1:0]     cur_r;
  logic              cur_valid_r;
  logic              done_r;
  logic [IW-1:0]     started_r;
  logic              full_r;
  logic              any_f_r, aft_f_r, use_f_r;
  logic [IW-1:0]     any_i_r, aft_i_r, use_i_r;
  logic              found_r, sw_r;
  logic [IW-1:0]     pick_r;

  logic              out_valid_r;
  logic              out_switched_r, out_old_valid_r, out_table_full_r, out_none_runnable_r;
  logic [SLOT_W-1:0] out_old_slot_r, out_new_slot_r, out_started_slot_r;
  logic [MS_W-1:0]   out_tick_count_r;

  slot_t             chain [NUM_SLOTS];
  slot_t             head;
  slot_t             edit;
  logic              shift, wake_en, runnable;
  logic              done_nxt;
  logic              any_f_nxt, aft_f_nxt, use_f_nxt;
  logic [IW-1:0]     any_i_nxt, aft_i_nxt, use_i_nxt;
  logic              found_nxt, sw_nxt;
  logic [IW-1:0]     pick_nxt;

  assign shift   = (state_r == S_PASS1) || (state_r == S_PASS2);
  assign wake_en = (state_r == S_PASS1) && (cmd_r == CMD_TICK);

  // Ring of slot cells; the tail takes the edited head word
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    rrss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .rst_val   ((i == 0) ? SLOT_RST_HEAD : SLOT_RST_FREE),
      .shift     (shift),
      .wake_en   (wake_en),
      .ms        (ms_r),
      .from_next ((i == NUM_SLOTS - 1) ? edit : chain[(i + 1) % NUM_SLOTS]),
      .to_prev   (chain[i])
    );
  end

  assign head     = chain[0];
  assign runnable = head.used && (head.status != ST_SLEEP);

  // Scan records: first runnable, first runnable after current, first used
  always_comb begin
    any_f_nxt = any_f_r || runnable;
    any_i_nxt = (!any_f_r && runnable) ? idx_r : any_i_r;
    aft_f_nxt = aft_f_r || (runnable && (idx_r > cur_r));
    aft_i_nxt = (!aft_f_r && runnable && (idx_r > cur_r)) ? idx_r : aft_i_r;
    use_f_nxt = use_f_r || head.used;
    use_i_nxt = (!use_f_r && head.used) ? idx_r : use_i_r;
  end

  // Pick at the end of the wake pass
  always_comb begin
    if (!cur_valid_r) begin
      found_nxt = use_f_nxt;
      pick_nxt  = use_i_nxt;
    end else if (aft_f_nxt) begin
      found_nxt = 1'b1;
      pick_nxt  = aft_i_nxt;
    end else begin
      found_nxt = any_f_nxt;
      pick_nxt  = any_i_nxt;
    end
    sw_nxt = found_nxt && (!cur_valid_r || (pick_nxt != cur_r));
  end

  // Edit of the slot passing the head
  always_comb begin
    edit     = head;
    done_nxt = done_r;
    unique case (cmd_r)
      CMD_TICK: begin
        if ((state_r == S_PASS2) && sw_r) begin
          if (cur_valid_r && (idx_r == cur_r) && (head.status != ST_SLEEP)) begin
            edit.status = ST_IDLE;
          end
          if (idx_r == pick_r) begin
            edit.status = ST_ACTIVE;
          end
        end
      end
      CMD_SLEEP: begin
        if (!done_r && head.used && (head.status == ST_ACTIVE)) begin
          edit.status = ST_SLEEP;
          edit.sbegin = ms_r;
          edit.slen   = {1'b0, dur_r};
          done_nxt    = 1'b1;
        end
      end
      CMD_START: begin
        if (!done_r && !head.used) begin
          edit      = SLOT_RST_FREE;
          edit.used = 1'b1;
          done_nxt  = 1'b1;
        end
      end
      CMD_END: begin
        if (cur_valid_r && (idx_r == cur_r)) begin
          edit = SLOT_RST_FREE;
        end
      end
      default: edit = head;
    endcase
  end

  // Sequencer, scheduler registers and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      cmd_r       <= CMD_TICK;
      ms_r        <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // Drain the output word; a load in S_DONE takes over this cycle
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r     <= in_command;
            dur_r     <= in_duration;
            if (in_command == CMD_TICK) begin
              ms_r <= ms_r + MS_W'(1);
            end
            idx_r     <= '0;
            done_r    <= 1'b0;
            started_r <= '0;
            full_r    <= 1'b0;
            any_f_r   <= 1'b0;
            aft_f_r   <= 1'b0;
            use_f_r   <= 1'b0;
            any_i_r   <= '0;
            aft_i_r   <= '0;
            use_i_r   <= '0;
            found_r   <= 1'b0;
            sw_r      <= 1'b0;
            pick_r    <= '0;
            state_r   <= S_PASS1;
          end
        end
        S_PASS1: begin
          idx_r   <= (idx_r == LAST) ? '0 : idx_r + IW'(1);
          done_r  <= done_nxt;
          any_f_r <= any_f_nxt;
          aft_f_r <= aft_f_nxt;
          use_f_r <= use_f_nxt;
          any_i_r <= any_i_nxt;
          aft_i_r <= aft_i_nxt;
          use_i_r <= use_i_nxt;
          if ((cmd_r == CMD_START) && done_nxt && !done_r) begin
            started_r <= idx_r;
          end
          if (idx_r == LAST) begin
            if (cmd_r == CMD_TICK) begin
              found_r <= found_nxt;
              pick_r  <= pick_nxt;
              sw_r    <= sw_nxt;
              state_r <= S_PASS2;
            end else begin
              state_r <= S_DONE;
            end
            if (cmd_r == CMD_START) begin
              full_r <= !done_nxt;
            end
          end
        end
        S_PASS2: begin
          idx_r <= (idx_r == LAST) ? '0 : idx_r + IW'(1);
          if (idx_r == LAST) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_switched_r      <= sw_r;
            out_old_valid_r     <= sw_r && cur_valid_r;
            out_old_slot_r      <= (sw_r && cur_valid_r) ? SLOT_W'(cur_r) : '0;
            out_new_slot_r      <= sw_r ? SLOT_W'(pick_r) : '0;
            out_started_slot_r  <= SLOT_W'(started_r);
            out_table_full_r    <= full_r;
            out_none_runnable_r <= (cmd_r == CMD_TICK) && !found_r;
            out_tick_count_r    <= ms_r;
            if (sw_r) begin
              cur_r       <= pick_r;
              cur_valid_r <= 1'b1;
            end
            if (cmd_r == CMD_END) begin
              cur_valid_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_switched      = out_switched_r;
  assign out_old_valid     = out_old_valid_r;
  assign out_old_slot      = out_old_slot_r;
  assign out_new_slot      = out_new_slot_r;
  assign out_started_slot  = out_started_slot_r;
  assign out_table_full    = out_table_full_r;
  assign out_none_runnable = out_none_runnable_r;
  assign out_tick_count    = out_tick_count_r;

endmodule

>>> rtl/rrss_check.sv
// Port-level checker for the scheduler, bound to the top level.
`include "round_robin_sleep_scheduler_macros.svh"

module rrss_check
  import rrss_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_switched,
  input logic              out_old_valid,
  input logic [SLOT_W-1:0] out_old_slot,
  input logic [SLOT_W-1:0] out_new_slot,
  input logic [SLOT_W-1:0] out_started_slot,
  input logic              out_table_full,
  input logic              out_none_runnable,
  input logic [MS_W-1:0]   out_tick_count
);

  // Stalled result word holds
  `RRSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_tick_count) && $stable(out_new_slot) && $stable(out_old_slot),
    "result word changed while stalled")

  // A context save only comes with a switch
  `RRSS_ASSERT_SAME(a_old_needs_switch, out_valid && out_old_valid, out_switched,
    "old_valid without switch")

  // Nothing runnable means no switch at all
  `RRSS_ASSERT_SAME(a_none_no_switch, out_valid && out_none_runnable,
    !out_switched && !out_old_valid, "switch with nothing runnable")

  // A refused start reports nothing else
  `RRSS_ASSERT_SAME(a_full_quiet, out_valid && out_table_full,
    !out_switched && !out_none_runnable && (out_started_slot == '0),
    "table_full with other flags")

  // One word at a time: busy right after an accept
  `RRSS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "ready right after accept")

endmodule

bind round_robin_sleep_scheduler rrss_check u_rrss_check (.*);

>>> verif/testbench.sv
// Self-checking testbench for the round-robin sleep scheduler.
module testbench;
  import rrss_pkg::*;

  localparam int SLOTS       = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2500;
  localparam int DRAIN_WAIT  = 4 * SLOTS + 8;
  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

  typedef struct packed {
    logic              switched;
    logic              old_valid;
    logic [SLOT_W-1:0] old_slot;
    logic [SLOT_W-1:0] new_slot;
    logic [SLOT_W-1:0] started_slot;
    logic              table_full;
    logic              none_runnable;
    logic [MS_W-1:0]   tick_count;
  } sched_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command;
  logic [DUR_W-1:0]  in_duration;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_switched;
  logic              out_old_valid;
  logic [SLOT_W-1:0] out_old_slot;
  logic [SLOT_W-1:0] out_new_slot;
  logic [SLOT_W-1:0] out_started_slot;
  logic              out_table_full;
  logic              out_none_runnable;
  logic [MS_W-1:0]   out_tick_count;

  // Predictor copy of the slot table
  logic            slot_busy   [SLOTS];
  logic [1:0]      slot_state  [SLOTS];
  logic [MS_W-1:0] nap_start   [SLOTS];
  logic [MS_W-1:0] nap_len     [SLOTS];
  logic [2:0]      run_slot;
  logic            run_valid;
  logic [MS_W-1:0] ms_now;

  sched_result_t pending_results[$];

  int errors = 0;
  int ticks_seen = 0, sleeps_seen = 0, starts_seen = 0, ends_seen = 0;
  int switch_count = 0, full_count = 0, empty_tick_count = 0;
  int quiet_cycles = 0;

  // Receiver stall control; a hold-off is asked for by toggling hold_req
  logic        hold_req  = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  logic [5:0]  stall_phase = '0;
  logic [1:0]  stall_mode  = '0;
  logic [15:0] stall_bits  = '1;

  round_robin_sleep_scheduler #(.NUM_SLOTS(SLOTS)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_duration       (in_duration),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_switched      (out_switched),
    .out_old_valid     (out_old_valid),
    .out_old_slot      (out_old_slot),
    .out_new_slot      (out_new_slot),
    .out_started_slot  (out_started_slot),
    .out_table_full    (out_table_full),
    .out_none_runnable (out_none_runnable),
    .out_tick_count    (out_tick_count)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void reset_table();
    for (int s = 0; s < SLOTS; s++) begin
      slot_busy[s]  = (s == 0);
      slot_state[s] = (s == 0) ? ST_ACTIVE : ST_IDLE;
      nap_start[s]  = '0;
      nap_len[s]    = '0;
    end
    run_slot  = '0;
    run_valid = 1'b1;
    ms_now    = '0;
  endfunction

  // Applies one word to the table copy and returns the result it should give
  function automatic sched_result_t schedule_word(input logic [CMD_W-1:0] cmd,
                                                  input logic [DUR_W-1:0] dur);
    sched_result_t r;
    logic          found;
    int            pick;
    int            c;
    r     = '0;
    found = 1'b0;
    pick  = 0;
    case (cmd)
      CMD_TICK: begin
        ms_now = ms_now + 1;
        // wake sleepers whose elapsed time exceeds the duration
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_busy[s] && slot_state[s] == ST_SLEEP &&
              (ms_now - nap_start[s]) > nap_len[s])
            slot_state[s] = ST_IDLE;
        end
        if (!run_valid) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!found && slot_busy[s]) begin
              found = 1'b1;
              pick  = s;
            end
          end
        end else begin
          for (int k = 1; k <= SLOTS; k++) begin
            c = (int'(run_slot) + k) % SLOTS;
            if (!found && slot_busy[c] && slot_state[c] != ST_SLEEP) begin
              found = 1'b1;
              pick  = c;
            end
          end
        end
        if (!found) begin
          r.none_runnable = 1'b1;
        end else if (!run_valid || pick != int'(run_slot)) begin
          if (run_valid) begin
            if (slot_state[run_slot] != ST_SLEEP) slot_state[run_slot] = ST_IDLE;
            r.old_valid = 1'b1;
            r.old_slot  = run_slot;
          end
          slot_state[pick] = ST_ACTIVE;
          r.switched = 1'b1;
          r.new_slot = pick[SLOT_W-1:0];
          run_slot   = pick[2:0];
          run_valid  = 1'b1;
        end
      end
      CMD_SLEEP: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!found && slot_busy[s] && slot_state[s] == ST_ACTIVE) begin
            found         = 1'b1;
            slot_state[s] = ST_SLEEP;
            nap_start[s]  = ms_now;
            nap_len[s]    = {1'b0, dur};
          end
        end
      end
      CMD_START: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!found && !slot_busy[s]) begin
            found          = 1'b1;
            slot_busy[s]   = 1'b1;
            slot_state[s]  = ST_IDLE;
            nap_start[s]   = '0;
            nap_len[s]     = '0;
            r.started_slot = s[SLOT_W-1:0];
          end
        end
        if (!found) r.table_full = 1'b1;
      end
      default: begin
        if (run_valid) begin
          slot_busy[run_slot]  = 1'b0;
          slot_state[run_slot] = ST_IDLE;
          nap_start[run_slot]  = '0;
          nap_len[run_slot]    = '0;
          run_valid            = 1'b0;
        end
      end
    endcase
    r.tick_count = ms_now;
    return r;
  endfunction

  // Input monitor: follow reset, predict on every accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_table();
    end else if (in_valid && in_ready) begin
      pending_results.push_back(schedule_word(in_command, in_duration));
      case (in_command)
        CMD_TICK:  ticks_seen++;
        CMD_SLEEP: sleeps_seen++;
        CMD_START: starts_seen++;
        default:   ends_seen++;
      endcase
      switch_count     += pending_results[$].switched;
      full_count       += pending_results[$].table_full;
      empty_tick_count += pending_results[$].none_runnable;
    end
  end

  task automatic check_field(input string name, input logic [MS_W-1:0] want,
                             input logic [MS_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("switched",      MS_W'(want.switched),      MS_W'(out_switched));
        check_field("old_valid",     MS_W'(want.old_valid),     MS_W'(out_old_valid));
        check_field("old_slot",      MS_W'(want.old_slot),      MS_W'(out_old_slot));
        check_field("new_slot",      MS_W'(want.new_slot),      MS_W'(out_new_slot));
        check_field("started_slot",  MS_W'(want.started_slot),  MS_W'(out_started_slot));
        check_field("table_full",    MS_W'(want.table_full),    MS_W'(out_table_full));
        check_field("none_runnable", MS_W'(want.none_runnable), MS_W'(out_none_runnable));
        check_field("tick_count",    want.tick_count,           out_tick_count);
      end
    end
  end

  // Receiver: long hold-off on request, else a random stall pattern that changes whenever stall_phase wraps
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      out_ready <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == '0) begin
        stall_mode <= 2'($urandom_range(0, 3));
        stall_bits <= 16'($urandom);
      end
      case (stall_mode)
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= stall_bits[stall_phase[3:0]];
        2'd2:    out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= stall_bits[stall_phase[5:2]];
      endcase
    end
  end

  // Watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one word and wait until it is taken; valid stays up for the next one
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DUR_W-1:0] dur);
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_duration <= dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return DUR_W'($urandom_range(0, 12));
    if (roll < 95) return DUR_W'($urandom_range(13, 80));
    return DUR_W'($urandom) & DUR_MAX;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return CMD_TICK;
    if (roll < 68) return CMD_SLEEP;
    if (roll < 85) return CMD_START;
    return CMD_END;
  endfunction

  // Corner cases: lone slot, all asleep, empty table, full table, wake boundary
  task automatic test_directed_corners();
    send_word(CMD_TICK, '0);           // only slot 0 runs: same slot, no switch
    send_word(CMD_SLEEP, DUR_MAX);     // slot 0 sleeps for the longest duration
    send_word(CMD_SLEEP, '0);          // nothing active: ignored
    send_word(CMD_TICK, DUR_MAX);      // nothing runnable
    send_word(CMD_END, '0);            // frees the sleeping current slot
    send_word(CMD_END, DUR_MAX);       // no current slot: ignored
    send_word(CMD_TICK, '0);           // empty table, no current
    for (int i = 0; i <= SLOTS; i++)   // fill the table, last one refused
      send_word(CMD_START, '0);
    send_word(CMD_TICK, '0);           // no current: lowest used, old_valid low
    send_word(CMD_TICK, '0);           // rotate 0 -> 1
    send_word(CMD_SLEEP, '0);          // zero-length sleep
    send_word(CMD_TICK, '0);           // wakes one tick later, moves on
    send_word(CMD_END, '0);
    send_word(CMD_START, DUR_MAX);     // reuses the freed slot
    send_word(CMD_SLEEP, 31'd1);
    send_word(CMD_TICK, '0);
    send_word(CMD_TICK, '0);
    sender_gap(1);
  endtask

  // Receiver holds off while words keep coming, so the block backs up
  task automatic test_backpressure();
    hold_req <= !hold_req;
    for (int i = 0; i < 40; i++)
      send_word(pick_command(), pick_duration());
    sender_gap(2);
  endtask

  // Random command mix in bursts with random gaps
  task automatic test_random_traffic(input int words);
    int burst_left;
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < words; i++) begin
      send_word(pick_command(), pick_duration());
      burst_left--;
      if (burst_left == 0) begin
        sender_gap($urandom_range(1, 10));
        burst_left = $urandom_range(1, 40);
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = CMD_TICK;
    in_duration = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_backpressure();
    test_random_traffic(1090);
    in_valid <= 1'b0;

    // Drain, then let any late word show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
    end

    $display("covered %0d ticks, %0d sleeps, %0d starts, %0d ends",
             ticks_seen, sleeps_seen, starts_seen, ends_seen);
    $display("saw %0d switches, %0d full-table refusals, %0d ticks with nothing runnable",
             switch_count, full_count, empty_tick_count);
    if ((errors == 0) && (pending_results.size() == 0)) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
